FILE: design/forth_memory_word_unit_defines.svh
// Assertion macros shared by the checker files of the memory word unit.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef FORTH_MEMORY_WORD_UNIT_DEFINES_SVH
`define FORTH_MEMORY_WORD_UNIT_DEFINES_SVH

// Same-cycle implication
`define FMWU_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication
`define FMWU_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/fmwu_pkg.sv
// Package for the memory word unit: field widths, op and error codes,
// sequencer types and the control store. No dependencies.
package fmwu_pkg;

    localparam int OP_W       = 3;
    localparam int CELL_W     = 32;
    localparam int DEPTH_W    = 7;
    localparam int HERE_W     = 13;
    localparam int ERR_W      = 3;
    localparam int CELL_BYTES = 4;
    localparam int UPC_W      = 5;

    typedef enum logic [OP_W-1:0] {
        OP_HERE, OP_ALLOT, OP_STORE, OP_FETCH, OP_BSTORE, OP_BFETCH, OP_CELLS, OP_LIT
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK, ERR_STACK_OVER, ERR_STACK_UNDER, ERR_SPACE_OVER, ERR_STORE_ADDR,
        ERR_FETCH_ADDR
    } err_t;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_t;

    // Control word fields
    typedef enum logic [2:0] {J_NONE, J_ALWAYS, J_BYTE, J_STKERR, J_CHKERR, J_ERRREG} jcond_t;
    typedef enum logic [1:0] {RD_NONE, RD_SECOND, RD_THIRD} srd_t;
    typedef enum logic [2:0] {TOP_KEEP, TOP_HERE, TOP_LIT, TOP_SHL2, TOP_STK, TOP_FETCH} top_t;
    typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC1, CNT_DEC2} cnt_t;
    typedef enum logic [1:0] {VAL_KEEP, VAL_STK, VAL_ZERO} val_t;
    typedef enum logic [1:0] {MEM_NONE, MEM_WR, MEM_RD} mem_t;

    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        logic   chk;      // evaluate the op's checks into the error register
        jcond_t jc;
        upc_t   jt;
        srd_t   rd;       // stack memory read below the top
        top_t   top;
        cnt_t   cnt;
        logic   here_ld;
        logic   addr_ld;
        val_t   val;
        mem_t   mem;      // byte space access at the address register
        logic   acc;      // merge the fetched byte into the value register
        logic   done;     // hand the result to the output register
    } uctl_t;

    // Step addresses
    localparam upc_t UA_DONE      = 5'd0;
    localparam upc_t UA_HERE_CHK  = 5'd1;
    localparam upc_t UA_HERE_PUSH = 5'd2;
    localparam upc_t UA_LIT_CHK   = 5'd3;
    localparam upc_t UA_LIT_PUSH  = 5'd4;
    localparam upc_t UA_CELLS_CHK = 5'd5;
    localparam upc_t UA_CELLS_SHL = 5'd6;
    localparam upc_t UA_ALLOT_CHK = 5'd7;
    localparam upc_t UA_ALLOT_POP = 5'd8;
    localparam upc_t UA_ST_CHK    = 5'd9;
    localparam upc_t UA_ST_VAL    = 5'd10;
    localparam upc_t UA_ST_POP    = 5'd11;
    localparam upc_t UA_ST_B0     = 5'd12;
    localparam upc_t UA_ST_B1     = 5'd13;
    localparam upc_t UA_ST_B2     = 5'd14;
    localparam upc_t UA_ST_B3     = 5'd15;
    localparam upc_t UA_FE_CHK    = 5'd16;
    localparam upc_t UA_FE_B0     = 5'd17;
    localparam upc_t UA_FE_B1     = 5'd18;
    localparam upc_t UA_FE_B2     = 5'd19;
    localparam upc_t UA_FE_B3     = 5'd20;
    localparam upc_t UA_FE_LAST   = 5'd21;

    localparam uctl_t UC_NOP = '{chk: 1'b0, jc: J_NONE, jt: UA_DONE, rd: RD_NONE,
                                 top: TOP_KEEP, cnt: CNT_KEEP, here_ld: 1'b0,
                                 addr_ld: 1'b0, val: VAL_KEEP, mem: MEM_NONE,
                                 acc: 1'b0, done: 1'b0};

    // First step of each word
    function automatic upc_t entry(input op_t o);
        upc_t a;
        a = UA_DONE;
        unique case (o) inside
            OP_HERE:             a = UA_HERE_CHK;
            OP_LIT:              a = UA_LIT_CHK;
            OP_CELLS:            a = UA_CELLS_CHK;
            OP_ALLOT:            a = UA_ALLOT_CHK;
            OP_STORE, OP_BSTORE: a = UA_ST_CHK;
            OP_FETCH, OP_BFETCH: a = UA_FE_CHK;
            default:             a = UA_DONE;
        endcase
        return a;
    endfunction

    // Control store
    function automatic uctl_t ucode(input upc_t a);
        uctl_t w;
        w = UC_NOP;
        unique case (a)
            UA_DONE:      w.done = 1'b1;
            // push of HERE or literal, and CELLS (shift the top left by two)
            UA_HERE_CHK, UA_LIT_CHK, UA_CELLS_CHK:
            begin
                w.chk = 1'b1;
                w.jc  = J_CHKERR;
            end
            UA_HERE_PUSH:
            begin
                w.top = TOP_HERE;
                w.cnt = CNT_INC;
                w.jc  = J_ALWAYS;
            end
            UA_LIT_PUSH:
            begin
                w.top = TOP_LIT;
                w.cnt = CNT_INC;
                w.jc  = J_ALWAYS;
            end
            UA_CELLS_SHL:
            begin
                w.top = TOP_SHL2;
                w.jc  = J_ALWAYS;
            end
            // allot: check range, move HERE, pop the count
            UA_ALLOT_CHK:
            begin
                w.chk = 1'b1;
                w.rd  = RD_SECOND;
                w.jc  = J_CHKERR;
            end
            UA_ALLOT_POP:
            begin
                w.here_ld = 1'b1;
                w.top     = TOP_STK;
                w.cnt     = CNT_DEC1;
                w.jc      = J_ALWAYS;
            end
            // store: operands are popped even when the address is bad
            UA_ST_CHK:
            begin
                w.chk     = 1'b1;
                w.rd      = RD_SECOND;
                w.addr_ld = 1'b1;
                w.jc      = J_STKERR;
            end
            UA_ST_VAL:
            begin
                w.val = VAL_STK;
                w.rd  = RD_THIRD;
            end
            UA_ST_POP:
            begin
                w.top = TOP_STK;
                w.cnt = CNT_DEC2;
                w.jc  = J_ERRREG;
            end
            UA_ST_B0:
            begin
                w.mem = MEM_WR;
                w.jc  = J_BYTE;
            end
            UA_ST_B1, UA_ST_B2: w.mem = MEM_WR;
            UA_ST_B3:
            begin
                w.mem = MEM_WR;
                w.jc  = J_ALWAYS;
            end
            // fetch: reads run one step ahead of the byte merge
            UA_FE_CHK:
            begin
                w.chk     = 1'b1;
                w.addr_ld = 1'b1;
                w.val     = VAL_ZERO;
                w.jc      = J_CHKERR;
            end
            UA_FE_B0:
            begin
                w.mem = MEM_RD;
                w.jc  = J_BYTE;
                w.jt  = UA_FE_LAST;
            end
            UA_FE_B1, UA_FE_B2, UA_FE_B3:
            begin
                w.mem = MEM_RD;
                w.acc = 1'b1;
            end
            UA_FE_LAST:
            begin
                w.acc = 1'b1;
                w.top = TOP_FETCH;
                w.jc  = J_ALWAYS;
            end
            default:      w.done = 1'b1;
        endcase
        return w;
    endfunction

endpackage

FILE: design/forth_memory_word_unit.sv
// Memory word unit: microcoded sequencer over a data stack and a byte space (uses fmwu_pkg).
// One request at a time: a new request is taken only once the sequencer has handed the last
// result to the output register. The pace is set by the single byte port of the data space
// (one byte per step) and the control store.
// After reset the data space is cleared, with in_ready low until the clearing pass ends.
module forth_memory_word_unit #(
    parameter int STACK_CELLS = 64,
    parameter int SPACE_BYTES = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fmwu_pkg::OP_W-1:0]            op,
    input  logic signed [fmwu_pkg::CELL_W-1:0]   literal,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fmwu_pkg::CELL_W-1:0]   top_value,
    output logic [fmwu_pkg::DEPTH_W-1:0]         depth,
    output logic [fmwu_pkg::HERE_W-1:0]          here_value,
    output logic [fmwu_pkg::ERR_W-1:0]           error_code
);
    import fmwu_pkg::*;

    localparam int CW = $clog2(STACK_CELLS + 1);
    localparam int SW = $clog2(STACK_CELLS);
    localparam int HW = $clog2(SPACE_BYTES + 1);
    localparam int AW = $clog2(SPACE_BYTES);

    state_t              state_reg, state_next;
    upc_t                upc_reg, upc_next;
    uctl_t               uc;
    op_t                 op_reg;
    logic [CELL_W-1:0]   lit_reg, top_reg, val_reg, stk_rd_reg, acc_val;
    logic [CW-1:0]       cnt_reg, cnt_m1, cnt_m2, cnt_m3;
    logic [SW-1:0]       stk_raddr;
    logic [HW-1:0]       here_reg;
    logic [AW-1:0]       addr_reg, clr_reg;
    logic [1:0]          idx_reg;
    logic [7:0]          byte_rd_reg;
    err_t                err_reg, chk_err;
    logic                stk_err, take, run, out_load, out_free, byte_op;
    logic                cnt_full, cnt_zero, cnt_lt2;
    logic                store_bad, fetch_bad, allot_bad;
    logic [32:0]         addr_sum, nbytes;
    logic signed [33:0]  allot_sum;
    logic [31:0]         cnt_wide, here_wide;

    logic                out_valid_reg;
    logic [CELL_W-1:0]   out_top_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    logic [HERE_W-1:0]   out_here_reg;
    err_t                out_err_reg;

    logic [CELL_W-1:0]   stk_mem [STACK_CELLS];
    logic [7:0]          space_mem [SPACE_BYTES];

    // Control word of the current step
    assign uc  = ucode(upc_reg);
    assign run = (state_reg == ST_RUN);

    // Stack pointers below the top
    assign cnt_m1   = cnt_reg - CW'(1);
    assign cnt_m2   = cnt_reg - CW'(2);
    assign cnt_m3   = cnt_reg - CW'(3);
    assign cnt_full = (cnt_reg == CW'(STACK_CELLS));
    assign cnt_zero = (cnt_reg == '0);
    assign cnt_lt2  = (cnt_reg < CW'(2));
    assign stk_raddr = (uc.rd == RD_THIRD) ? cnt_m3[SW-1:0] : cnt_m2[SW-1:0];

    // Address and range checks on the top cell
    assign byte_op   = (op_reg == OP_BSTORE) || (op_reg == OP_BFETCH);
    assign nbytes    = byte_op ? 33'd1 : 33'(CELL_BYTES);
    assign addr_sum  = {1'b0, top_reg} + nbytes;
    assign store_bad = top_reg[CELL_W-1] || (addr_sum > 33'(here_reg));
    assign fetch_bad = top_reg[CELL_W-1] || (addr_sum > 33'(SPACE_BYTES));
    assign allot_sum = $signed({{(34-HW){1'b0}}, here_reg})
                     + $signed({{2{top_reg[CELL_W-1]}}, top_reg});
    assign allot_bad = allot_sum[33] || (allot_sum > $signed(34'(SPACE_BYTES)));

    // Error of the current word; stack errors take precedence
    always_comb
    begin
        stk_err = 1'b0;
        chk_err = ERR_OK;
        case (op_reg) inside
            OP_HERE, OP_LIT:
            begin
                if (cnt_full)
                begin
                    stk_err = 1'b1;
                    chk_err = ERR_STACK_OVER;
                end
            end
            OP_CELLS:
            begin
                if (cnt_zero)
                begin
                    stk_err = 1'b1;
                    chk_err = ERR_STACK_UNDER;
                end
            end
            OP_ALLOT:
            begin
                if (cnt_zero)
                begin
                    stk_err = 1'b1;
                    chk_err = ERR_STACK_UNDER;
                end
                else if (allot_bad)
                    chk_err = ERR_SPACE_OVER;
            end
            OP_STORE, OP_BSTORE:
            begin
                if (cnt_lt2)
                begin
                    stk_err = 1'b1;
                    chk_err = ERR_STACK_UNDER;
                end
                else if (store_bad)
                    chk_err = ERR_STORE_ADDR;
            end
            OP_FETCH, OP_BFETCH:
            begin
                if (cnt_zero)
                begin
                    stk_err = 1'b1;
                    chk_err = ERR_STACK_UNDER;
                end
                else if (fetch_bad)
                    chk_err = ERR_FETCH_ADDR;
            end
            default: ;
        endcase
    end

    // Jump condition
    always_comb
    begin
        case (uc.jc)
            J_ALWAYS: take = 1'b1;
            J_BYTE:   take = byte_op;
            J_STKERR: take = stk_err;
            J_CHKERR: take = (chk_err != ERR_OK);
            J_ERRREG: take = (err_reg != ERR_OK);
            default:  take = 1'b0;
        endcase
    end

    // Fetched byte merged into the value register at the byte index
    always_comb
    begin
        acc_val = val_reg;
        acc_val[{idx_reg, 3'b000} +: 8] = byte_rd_reg;
    end

    assign out_free = !out_valid_reg || out_ready;

    // Sequencer state and step counter
    always_comb
    begin
        state_next = state_reg;
        upc_next   = upc_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(SPACE_BYTES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    upc_next   = entry(op_t'(op));
                end
            end
            ST_RUN:
            begin
                if (uc.done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (take)
                    upc_next = uc.jt;
                else
                    upc_next = upc_reg + UPC_W'(1);
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            upc_reg       <= UA_DONE;
            cnt_reg       <= '0;
            here_reg      <= '0;
            clr_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (run)
            begin
                case (uc.cnt)
                    CNT_INC:  cnt_reg <= cnt_reg + CW'(1);
                    CNT_DEC1: cnt_reg <= cnt_m1;
                    CNT_DEC2: cnt_reg <= cnt_m2;
                    default:  ;
                endcase
                if (uc.here_ld)
                    here_reg <= allot_sum[HW-1:0];
                if (uc.val == VAL_ZERO)
                    idx_reg <= '0;
                else if (uc.acc)
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    assign cnt_wide  = 32'(cnt_reg);
    assign here_wide = 32'(here_reg);

    // Datapath and output registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= op_t'(op);
            lit_reg <= literal;
        end
        if (out_load)
        begin
            out_top_reg   <= cnt_zero ? '0 : top_reg;
            out_depth_reg <= cnt_wide[DEPTH_W-1:0];
            out_here_reg  <= here_wide[HERE_W-1:0];
            out_err_reg   <= err_reg;
        end
        if (run)
        begin
            if (uc.chk)
                err_reg <= chk_err;
            case (uc.top)
                TOP_HERE:  top_reg <= CELL_W'(here_reg);
                TOP_LIT:   top_reg <= lit_reg;
                TOP_SHL2:  top_reg <= {top_reg[CELL_W-3:0], 2'b00};
                TOP_STK:   top_reg <= stk_rd_reg;
                TOP_FETCH: top_reg <= acc_val;
                default:   ;
            endcase
            if (uc.addr_ld)
                addr_reg <= top_reg[AW-1:0];
            else if (uc.mem != MEM_NONE)
                addr_reg <= addr_reg + AW'(1);
            case (uc.val)
                VAL_STK:  val_reg <= stk_rd_reg;
                VAL_ZERO: val_reg <= '0;
                default:
                begin
                    if (uc.mem == MEM_WR)
                        val_reg <= {8'd0, val_reg[CELL_W-1:8]};
                    else if (uc.acc)
                        val_reg <= acc_val;
                end
            endcase
        end
    end

    // Stack memory: cells below the top, one write and one read port
    always_ff @(posedge clk)
    begin
        if (run && (uc.cnt == CNT_INC) && !cnt_zero)
            stk_mem[cnt_m1[SW-1:0]] <= top_reg;
        if (uc.rd != RD_NONE)
            stk_rd_reg <= stk_mem[stk_raddr];
    end

    // Byte space: clearing pass after reset, then byte writes and reads
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            space_mem[clr_reg] <= '0;
        else if (run && (uc.mem == MEM_WR))
            space_mem[addr_reg] <= val_reg[7:0];
        byte_rd_reg <= space_mem[addr_reg];
    end

    assign out_valid  = out_valid_reg;
    assign top_value  = out_top_reg;
    assign depth      = out_depth_reg;
    assign here_value = out_here_reg;
    assign error_code = out_err_reg;

endmodule

FILE: design/fmwu_chk.sv
// Port-level checker for the memory word unit, bound to the top level.
// Depends on fmwu_pkg and forth_memory_word_unit_defines.svh.
`include "forth_memory_word_unit_defines.svh"

module fmwu_chk #(
    parameter int STACK_CELLS = 64
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [fmwu_pkg::CELL_W-1:0]   top_value,
    input logic [fmwu_pkg::DEPTH_W-1:0]         depth,
    input logic [fmwu_pkg::HERE_W-1:0]          here_value,
    input logic [fmwu_pkg::ERR_W-1:0]           error_code
);
    import fmwu_pkg::*;

    // Only defined error codes are reported
    `FMWU_ASSERT_IMP(a_err_range, out_valid, error_code <= ERR_FETCH_ADDR)

    // An empty stack reports a zero top
    `FMWU_ASSERT_IMP(a_empty_top, (STACK_CELLS < 128) && out_valid && depth == '0, top_value == '0)

    // One request in flight: ready drops right after a request is taken
    `FMWU_ASSERT_NXT(a_one_req, in_valid && in_ready, !in_ready)

    // A stalled result stays put
    `FMWU_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(top_value) && $stable(here_value))

endmodule

bind forth_memory_word_unit fmwu_chk #(.STACK_CELLS(STACK_CELLS)) u_fmwu_chk (.*);
